// File: sv/iqa_pkg.sv
`default_nettype none

package iqa_pkg;

  // Default sizes for the top-level parameters.
  localparam int unsigned QueueDepthDef = 16;
  localparam int unsigned TimeBitsDef   = 16;

  // Fixed field widths.
  localparam int unsigned NumRoads  = 4;
  localparam int unsigned TaskBits  = 16;
  localparam int unsigned ArrInBits = 16;

  // Action codes.
  localparam logic [1:0] ACT_ENQUEUE   = 2'd0;
  localparam logic [1:0] ACT_RELEASE   = 2'd1;
  localparam logic [1:0] ACT_UNRESERVE = 2'd2;

  // Status codes.
  localparam logic [1:0] STAT_DONE      = 2'd0;
  localparam logic [1:0] STAT_FULL      = 2'd1;
  localparam logic [1:0] STAT_NOTHING   = 2'd2;

  // Road codes.
  localparam logic [1:0] ROAD_N = 2'd0;
  localparam logic [1:0] ROAD_E = 2'd1;
  localparam logic [1:0] ROAD_S = 2'd2;
  localparam logic [1:0] ROAD_W = 2'd3;

  // Turn codes.
  localparam logic [1:0] TURN_RIGHT    = 2'd0;
  localparam logic [1:0] TURN_STRAIGHT = 2'd1;
  localparam logic [1:0] TURN_LEFT     = 2'd2;

  // Quadrant bits: bit0 SE, bit1 SW, bit2 NE, bit3 NW.
  localparam logic [3:0] Q_SE = 4'b0001;
  localparam logic [3:0] Q_SW = 4'b0010;
  localparam logic [3:0] Q_NE = 4'b0100;
  localparam logic [3:0] Q_NW = 4'b1000;

  // One accepted input item.
  typedef struct packed {
    logic [1:0]           action;
    logic [1:0]           road;
    logic [1:0]           turn;
    logic [ArrInBits-1:0] arrival_time;
    logic [1:0]           quadrant;
  } item_t;

  // One result item.
  typedef struct packed {
    logic [1:0]          status;
    logic                released_valid;
    logic [1:0]          released_road;
    logic [1:0]          released_turn;
    logic [TaskBits-1:0] released_task_number;
    logic [3:0]          quadrants_busy;
  } result_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic take_item;  // latch the item and read the four queue heads
    logic execute;    // apply the item and load the result register
  } cmd_t;

  // Quadrants that a vehicle needs for its road and movement.
  // An out-of-range turn code counts as a left turn.
  function automatic logic [3:0] need_mask(logic [1:0] road, logic [1:0] turn);
    logic [3:0] entry;
    logic [3:0] second;
    logic [3:0] third;
    entry  = Q_NW;
    second = Q_SW;
    third  = Q_SE;
    unique case (road)
      ROAD_N: begin
        entry = Q_NW; second = Q_SW; third = Q_SE;
      end
      ROAD_E: begin
        entry = Q_NE; second = Q_NW; third = Q_SW;
      end
      ROAD_S: begin
        entry = Q_SE; second = Q_NE; third = Q_NW;
      end
      default: begin
        entry = Q_SW; second = Q_SE; third = Q_NE;
      end
    endcase
    case (turn)
      TURN_RIGHT:    need_mask = entry;
      TURN_STRAIGHT: need_mask = entry | second;
      default:       need_mask = entry | second | third;
    endcase
  endfunction

endpackage

`default_nettype wire

// File: sv/iqa_in_if.sv
`default_nettype none

// Input channel: one vehicle command per transfer.
interface iqa_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [1:0]  road;
  logic [1:0]  turn;
  logic [15:0] arrival_time;
  logic [1:0]  quadrant;

  modport source (output valid, action, road, turn, arrival_time, quadrant, input ready);
  modport sink   (input valid, action, road, turn, arrival_time, quadrant, output ready);
endinterface

`default_nettype wire

// File: sv/iqa_out_if.sv
`default_nettype none

// Output channel: one result per transfer.
interface iqa_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  status;
  logic        released_valid;
  logic [1:0]  released_road;
  logic [1:0]  released_turn;
  logic [15:0] released_task_number;
  logic [3:0]  quadrants_busy;

  modport source (output valid, status, released_valid, released_road, released_turn,
                  released_task_number, quadrants_busy, input ready);
  modport sink   (input valid, status, released_valid, released_road, released_turn,
                  released_task_number, quadrants_busy, output ready);
endinterface

`default_nettype wire

// File: sv/iqa_ram.sv
`default_nettype none

// Simple dual-port RAM: one write port, one read port with registered data.
module iqa_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 16
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(DEPTH)-1:0] waddr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  input  wire logic                     re_i,
  input  wire logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic      [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_o <= mem_q[raddr_i];
    end
  end

endmodule

`default_nettype wire

// File: sv/iqa_datapath.sv
`default_nettype none

module iqa_datapath import iqa_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDef,
  parameter int unsigned TIME_BITS   = TimeBitsDef
) (
  input  wire logic    clk_i,
  input  wire logic    rst_ni,
  input  wire cmd_t    cmd_i,
  input  wire item_t   item_i,
  output result_t      result_o
);

  localparam int unsigned AW = $clog2(QUEUE_DEPTH);
  localparam int unsigned CW = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned EW = TIME_BITS + 2 + TaskBits;

  // Latched item; the turn is saturated and the arrival cut to TIME_BITS.
  logic [1:0]           action_q, road_q, turn_q, quad_q;
  logic [TIME_BITS-1:0] arr_q;
  logic [TIME_BITS+ArrInBits-1:0] arr_wide;

  assign arr_wide = {{TIME_BITS{1'b0}}, item_i.arrival_time};

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_item) begin
      action_q <= item_i.action;
      road_q   <= item_i.road;
      turn_q   <= (item_i.turn > TURN_LEFT) ? TURN_LEFT : item_i.turn;
      arr_q    <= arr_wide[TIME_BITS-1:0];
      quad_q   <= item_i.quadrant;
    end
  end

  // Queue control state.
  logic [AW-1:0]       head_q [NumRoads];
  logic [AW-1:0]       tail_q [NumRoads];
  logic [CW-1:0]       count_q [NumRoads];
  logic [3:0]          flags_q, flags_d;
  logic [TaskBits-1:0] task_q;

  // One queue memory per road, read at its head while the item is taken.
  logic [EW-1:0]        rdata [NumRoads];
  logic [TIME_BITS-1:0] head_arr [NumRoads];
  logic [1:0]           head_turn [NumRoads];
  logic [TaskBits-1:0]  head_task [NumRoads];
  logic                 full;
  logic                 do_enq;

  assign full   = (count_q[road_q] == CW'(QUEUE_DEPTH));
  assign do_enq = cmd_i.execute && (action_q == ACT_ENQUEUE) && !full;

  for (genvar r = 0; r < NumRoads; r++) begin : g_queue
    iqa_ram #(
      .WIDTH (EW),
      .DEPTH (QUEUE_DEPTH)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (do_enq && (road_q == 2'(r))),
      .waddr_i (tail_q[r]),
      .wdata_i ({arr_q, turn_q, task_q}),
      .re_i    (cmd_i.take_item),
      .raddr_i (head_q[r]),
      .rdata_o (rdata[r])
    );
    assign head_arr[r]  = rdata[r][EW-1 -: TIME_BITS];
    assign head_turn[r] = rdata[r][TaskBits +: 2];
    assign head_task[r] = rdata[r][TaskBits-1:0];
  end

  // Pick the earliest free head; ties to lower turn code, then road order.
  logic                 found;
  logic [1:0]           best;
  logic [TIME_BITS-1:0] best_arr;
  logic [1:0]           best_turn;
  logic [TaskBits-1:0]  best_task;

  always_comb begin
    found     = 1'b0;
    best      = ROAD_N;
    best_arr  = '0;
    best_turn = TURN_RIGHT;
    best_task = '0;
    for (int r = 0; r < NumRoads; r++) begin
      if ((count_q[r] != '0) && ((need_mask(2'(r), head_turn[r]) & flags_q) == 4'b0000)) begin
        if (!found || (head_arr[r] < best_arr) ||
            ((head_arr[r] == best_arr) && (head_turn[r] < best_turn))) begin
          found     = 1'b1;
          best      = 2'(r);
          best_arr  = head_arr[r];
          best_turn = head_turn[r];
          best_task = head_task[r];
        end
      end
    end
  end

  logic do_rel;
  assign do_rel = cmd_i.execute && (action_q == ACT_RELEASE) && found;

  // Quadrant occupancy after the item.
  always_comb begin
    flags_d = flags_q;
    case (action_q)
      ACT_RELEASE: begin
        if (found) begin
          flags_d = flags_q | need_mask(best, best_turn);
        end
      end
      ACT_UNRESERVE: flags_d = flags_q & ~(4'b0001 << quad_q);
      default:       flags_d = flags_q;
    endcase
  end

  // Control state updates.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int r = 0; r < NumRoads; r++) begin
        head_q[r]  <= '0;
        tail_q[r]  <= '0;
        count_q[r] <= '0;
      end
      flags_q <= '0;
      task_q  <= '0;
    end else if (cmd_i.execute) begin
      flags_q <= flags_d;
      if (do_enq) begin
        tail_q[road_q]  <= (tail_q[road_q] == AW'(QUEUE_DEPTH - 1)) ? '0 : tail_q[road_q] + 1'b1;
        count_q[road_q] <= count_q[road_q] + 1'b1;
        task_q          <= task_q + 1'b1;
      end
      if (do_rel) begin
        head_q[best]  <= (head_q[best] == AW'(QUEUE_DEPTH - 1)) ? '0 : head_q[best] + 1'b1;
        count_q[best] <= count_q[best] - 1'b1;
      end
    end
  end

  // Result register.
  always_ff @(posedge clk_i) begin
    if (cmd_i.execute) begin
      result_o.status               <= STAT_DONE;
      result_o.released_valid       <= 1'b0;
      result_o.released_road        <= '0;
      result_o.released_turn        <= '0;
      result_o.released_task_number <= '0;
      result_o.quadrants_busy       <= flags_d;
      if ((action_q == ACT_ENQUEUE) && full) begin
        result_o.status <= STAT_FULL;
      end
      if (action_q == ACT_RELEASE) begin
        if (found) begin
          result_o.released_valid       <= 1'b1;
          result_o.released_road        <= best;
          result_o.released_turn        <= best_turn;
          result_o.released_task_number <= best_task;
        end else begin
          result_o.status <= STAT_NOTHING;
        end
      end
    end
  end

endmodule

`default_nettype wire

// File: sv/iqa_ctrl.sv
`default_nettype none

module iqa_ctrl import iqa_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output cmd_t      cmd_o
);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic state_q, state_d;
  logic out_valid_q, out_valid_d;
  logic in_xfer, out_xfer;

  // Take an item when idle and the result register is free or being emptied.
  assign in_ready_o  = (state_q == ST_IDLE) && (!out_valid_q || out_ready_i);
  assign in_xfer     = in_valid_i && in_ready_o;
  assign out_xfer    = out_valid_q && out_ready_i;
  assign out_valid_o = out_valid_q;

  assign cmd_o.take_item = in_xfer;
  assign cmd_o.execute   = (state_q == ST_EXEC);

  // Next-state logic.
  always_comb begin
    state_d     = state_q;
    out_valid_d = out_valid_q;
    if (out_xfer) begin
      out_valid_d = 1'b0;
    end
    unique case (state_q)
      ST_IDLE: begin
        if (in_xfer) begin
          state_d = ST_EXEC;
        end
      end
      ST_EXEC: begin
        state_d     = ST_IDLE;
        out_valid_d = 1'b1;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // An accepted item is executed in the next cycle.
  a_take_then_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_xfer |=> (state_q == ST_EXEC))
    else $error("accepted item was not executed");

  // Execution always leaves a result waiting.
  a_exec_gives_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EXEC) |=> out_valid_q)
    else $error("execution produced no result");

  // No new item while one is executing.
  a_no_take_in_exec: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EXEC) |-> !in_ready_o)
    else $error("input ready during execution");

  // Execution never overwrites a result that has not been transferred.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EXEC) |-> !out_valid_q || $past(out_xfer) || !$past(out_valid_q))
    else $error("result overwritten before transfer");

endmodule

`default_nettype wire

// File: sv/intersection_quadrant_arbiter.sv
// A result is registered once its item is applied; no new item is taken
// while one executes. The queue heads are read from the per-road RAMs in
// the transfer cycle and the item is applied in the next.
// Reset (asynchronous, active low) empties all queues, frees all quadrants
// and clears the task counter; queue RAM contents are not cleared.
`default_nettype none

module intersection_quadrant_arbiter import iqa_pkg::*; #(
  parameter int unsigned QUEUE_DEPTH = QueueDepthDef,
  parameter int unsigned TIME_BITS   = TimeBitsDef
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  iqa_in_if.sink    in_i,
  iqa_out_if.source out_o
);

  cmd_t    cmd;
  item_t   item;
  result_t result;

  assign item.action       = in_i.action;
  assign item.road         = in_i.road;
  assign item.turn         = in_i.turn;
  assign item.arrival_time = in_i.arrival_time;
  assign item.quadrant     = in_i.quadrant;

  // Handshake control.
  iqa_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_i.valid),
    .in_ready_o  (in_i.ready),
    .out_valid_o (out_o.valid),
    .out_ready_i (out_o.ready),
    .cmd_o       (cmd)
  );

  // Queues, quadrant flags and release selection.
  iqa_datapath #(
    .QUEUE_DEPTH (QUEUE_DEPTH),
    .TIME_BITS   (TIME_BITS)
  ) u_datapath (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .cmd_i    (cmd),
    .item_i   (item),
    .result_o (result)
  );

  assign out_o.status               = result.status;
  assign out_o.released_valid       = result.released_valid;
  assign out_o.released_road        = result.released_road;
  assign out_o.released_turn        = result.released_turn;
  assign out_o.released_task_number = result.released_task_number;
  assign out_o.quadrants_busy       = result.quadrants_busy;

endmodule

`default_nettype wire
